// ===== design/cdnc_pkg.sv =====
package cdnc_pkg;

   localparam int unsigned PipeDepth = 11;

   localparam logic [13:0] MaxYear    = 14'd9999;
   localparam logic [3:0]  MaxMonth   = 4'd12;
   localparam logic [22:0] EpochShift = 23'd719468;
   localparam logic [17:0] DaysPerEra = 18'd146097;

   localparam logic signed [23:0] MinDayNumber = -24'sd719162;
   localparam logic signed [23:0] MaxDayNumber = 24'sd2932896;

   // reciprocal multipliers: q = (x * K) >> S, K = ceil(2^S / d), x_max * d <= 2^S
   localparam int unsigned   Shift100    = 21;
   localparam logic [14:0]   Recip100    = 15'((2 ** 21 + 99) / 100);
   localparam int unsigned   Shift146097 = 40;
   localparam logic [22:0]   Recip146097 = 23'(((64'd1 << 40) / 64'd146097) + 64'd1);
   localparam int unsigned   Shift1460   = 29;
   localparam logic [18:0]   Recip1460   = 19'((2 ** 29 + 1459) / 1460);
   localparam int unsigned   Shift365    = 27;
   localparam logic [18:0]   Recip365    = 19'((2 ** 27 + 364) / 365);
   localparam int unsigned   Shift153    = 19;
   localparam logic [11:0]   Recip153    = 12'((2 ** 19 + 152) / 153);

   typedef struct packed {
      logic               vld;
      logic               date_ok;
      logic [13:0]        ya;
      logic [6:0]         cent;
      logic [8:0]         doy;
      logic signed [22:0] offset;
   } check_type;

   typedef struct packed {
      logic               vld;
      logic               date_ok;
      logic signed [22:0] day_number;
      logic               sum_ok;
      logic [21:0]        z;
   } days_type;

   typedef struct packed {
      logic               vld;
      logic               date_ok;
      logic signed [22:0] day_number;
      logic               sum_ok;
   } tag_type;

   function automatic logic [4:0] month_length(input logic [3:0] month);
      logic [4:0] len;
      unique case (month)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         4'd2: len = 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

   // first day of a month counted from March 1
   function automatic logic [8:0] march_start(input logic [3:0] mi);
      logic [8:0] start_day;
      unique case (mi)
         4'd0:  start_day = 9'd0;
         4'd1:  start_day = 9'd31;
         4'd2:  start_day = 9'd61;
         4'd3:  start_day = 9'd92;
         4'd4:  start_day = 9'd122;
         4'd5:  start_day = 9'd153;
         4'd6:  start_day = 9'd184;
         4'd7:  start_day = 9'd214;
         4'd8:  start_day = 9'd245;
         4'd9:  start_day = 9'd275;
         4'd10: start_day = 9'd306;
         4'd11: start_day = 9'd337;
         default: start_day = 9'd0;
      endcase
      return start_day;
   endfunction

endpackage

// ===== design/cdnc_check.sv =====
module cdnc_check (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_vld,
   input  logic [13:0]           year,
   input  logic [3:0]            month,
   input  logic [4:0]            day,
   input  logic signed [22:0]    offset,
   output cdnc_pkg::check_type   chk_out
);

   logic                s1_vld_ff, s1_vld_in;
   logic [13:0]         s1_year_ff, s1_year_in;
   logic [3:0]          s1_month_ff, s1_month_in;
   logic [4:0]          s1_day_ff, s1_day_in;
   logic signed [22:0]  s1_offset_ff, s1_offset_in;
   logic [7:0]          s1_cent_ff, s1_cent_in;
   logic                s1_range_ok_ff, s1_range_ok_in;
   logic [28:0]         cent_prod;

   cdnc_pkg::check_type chk_ff, chk_in;

   logic                rem_zero;
   logic                leap;
   logic [4:0]          mlen;
   logic                early;
   logic [7:0]          cent_ya;
   logic [3:0]          mi;

   assign cent_prod      = 29'(year) * 29'(cdnc_pkg::Recip100);
   assign s1_vld_in      = in_vld;
   assign s1_year_in     = year;
   assign s1_month_in    = month;
   assign s1_day_in      = day;
   assign s1_offset_in   = offset;
   assign s1_cent_in     = cent_prod[28:cdnc_pkg::Shift100];
   assign s1_range_ok_in = (year != 14'd0) && (year <= cdnc_pkg::MaxYear) &&
                           (month != 4'd0) && (month <= cdnc_pkg::MaxMonth) &&
                           (day != 5'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      s1_year_ff     <= s1_year_in;
      s1_month_ff    <= s1_month_in;
      s1_day_ff      <= s1_day_in;
      s1_offset_ff   <= s1_offset_in;
      s1_cent_ff     <= s1_cent_in;
      s1_range_ok_ff <= s1_range_ok_in;
   end

   always_comb begin
      rem_zero = (s1_year_ff == 14'(s1_cent_ff) * 14'd100);
      leap     = rem_zero ? (s1_cent_ff[1:0] == 2'd0) : (s1_year_ff[1:0] == 2'd0);
      mlen     = (s1_month_ff == 4'd2 && leap) ? 5'd29 :
                 cdnc_pkg::month_length(s1_month_ff);
      early    = (s1_month_ff <= 4'd2);
      cent_ya  = s1_cent_ff - {7'd0, early && rem_zero};
      mi       = early ? s1_month_ff + 4'd9 : s1_month_ff - 4'd3;

      chk_in.vld     = s1_vld_ff;
      chk_in.date_ok = s1_range_ok_ff && (s1_day_ff <= mlen);
      chk_in.ya      = s1_year_ff - {13'd0, early};
      chk_in.cent    = cent_ya[6:0];
      chk_in.doy     = cdnc_pkg::march_start(mi) + 9'(s1_day_ff) - 9'd1;
      chk_in.offset  = s1_offset_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff.vld <= 1'b0;
      end else begin
         chk_ff.vld <= chk_in.vld;
      end
      chk_ff.date_ok <= chk_in.date_ok;
      chk_ff.ya      <= chk_in.ya;
      chk_ff.cent    <= chk_in.cent;
      chk_ff.doy     <= chk_in.doy;
      chk_ff.offset  <= chk_in.offset;
   end

   assign chk_out = chk_ff;

endmodule

// ===== design/cdnc_to_days.sv =====
module cdnc_to_days (
   input  logic                 clock,
   input  logic                 reset,
   input  cdnc_pkg::check_type  chk_in,
   output cdnc_pkg::days_type   days_out
);

   logic                s3_vld_ff, s3_vld_in;
   logic                s3_date_ok_ff, s3_date_ok_in;
   logic signed [22:0]  s3_dn_ff, s3_dn_in;
   logic signed [22:0]  s3_offset_ff, s3_offset_in;

   logic [24:0]         dn_pos;
   logic [24:0]         dn_raw;
   logic [23:0]         sum_bits;
   logic signed [23:0]  sum_val;
   logic [23:0]         z_full;

   cdnc_pkg::days_type  days_ff, days_in;

   assign dn_pos = 25'(chk_in.ya) * 25'd365 + 25'(chk_in.ya[13:2]) +
                   25'(chk_in.cent[6:2]) + 25'(chk_in.doy);
   assign dn_raw = dn_pos - 25'(chk_in.cent) - 25'(cdnc_pkg::EpochShift);

   assign s3_vld_in     = chk_in.vld;
   assign s3_date_ok_in = chk_in.date_ok;
   assign s3_dn_in      = $signed(dn_raw[22:0]);
   assign s3_offset_in  = chk_in.offset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else begin
         s3_vld_ff <= s3_vld_in;
      end
      s3_date_ok_ff <= s3_date_ok_in;
      s3_dn_ff      <= s3_dn_in;
      s3_offset_ff  <= s3_offset_in;
   end

   always_comb begin
      sum_bits = {s3_dn_ff[22], s3_dn_ff} + {s3_offset_ff[22], s3_offset_ff};
      sum_val  = $signed(sum_bits);
      z_full   = sum_bits + {1'b0, cdnc_pkg::EpochShift};

      days_in.vld        = s3_vld_ff;
      days_in.date_ok    = s3_date_ok_ff;
      days_in.day_number = s3_dn_ff;
      days_in.sum_ok     = s3_date_ok_ff && (sum_val >= cdnc_pkg::MinDayNumber) &&
                           (sum_val <= cdnc_pkg::MaxDayNumber);
      days_in.z          = z_full[21:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         days_ff.vld <= 1'b0;
      end else begin
         days_ff.vld <= days_in.vld;
      end
      days_ff.date_ok    <= days_in.date_ok;
      days_ff.day_number <= days_in.day_number;
      days_ff.sum_ok     <= days_in.sum_ok;
      days_ff.z          <= days_in.z;
   end

   assign days_out = days_ff;

endmodule

// ===== design/cdnc_from_days.sv =====
module cdnc_from_days (
   input  logic                clock,
   input  logic                reset,
   input  cdnc_pkg::days_type  days_in,
   output logic                res_vld,
   output logic                date_valid,
   output logic signed [22:0]  day_number,
   output logic                sum_valid,
   output logic [13:0]         sum_year,
   output logic [3:0]          sum_month,
   output logic [4:0]          sum_day
);

   localparam int unsigned TagStages = 6;

   cdnc_pkg::tag_type   tag_ff [TagStages];
   cdnc_pkg::tag_type   tag_in [TagStages];

   // era
   logic [44:0]  era_prod;
   logic [21:0]  s5_z_ff, s5_z_in;
   logic [4:0]   s5_era_ff, s5_era_in;
   // day of era
   logic [21:0]  doe_full;
   logic [17:0]  s6_doe_ff, s6_doe_in;
   logic [4:0]   s6_era_ff;
   // leap corrected day count
   logic [36:0]  q1460_prod;
   logic [7:0]   q1460;
   logic [2:0]   q36524;
   logic         q146096;
   logic [17:0]  s7_t_ff, s7_t_in;
   logic [17:0]  s7_doe_ff;
   logic [4:0]   s7_era_ff;
   // year of era
   logic [36:0]  yoe_prod;
   logic [8:0]   s8_yoe_ff, s8_yoe_in;
   logic [17:0]  s8_doe_ff;
   logic [4:0]   s8_era_ff;
   // day of year
   logic [1:0]   y100;
   logic [17:0]  year_base;
   logic [17:0]  doy_full;
   logic [8:0]   s9_doy_ff, s9_doy_in;
   logic [8:0]   s9_yoe_ff;
   logic [4:0]   s9_era_ff;
   // month from March
   logic [10:0]  mp_num;
   logic [22:0]  mp_prod;
   logic [3:0]   s10_mp_ff, s10_mp_in;
   logic [8:0]   s10_doy_ff;
   logic [8:0]   s10_yoe_ff;
   logic [4:0]   s10_era_ff;
   // result
   logic [8:0]   day_full;
   logic [3:0]   month_val;
   logic [13:0]  year_val;

   logic                out_vld_ff, out_vld_in;
   logic                out_date_valid_ff, out_date_valid_in;
   logic signed [22:0]  out_day_number_ff, out_day_number_in;
   logic                out_sum_valid_ff, out_sum_valid_in;
   logic [13:0]         out_sum_year_ff, out_sum_year_in;
   logic [3:0]          out_sum_month_ff, out_sum_month_in;
   logic [4:0]          out_sum_day_ff, out_sum_day_in;

   always_comb begin
      tag_in[0].vld        = days_in.vld;
      tag_in[0].date_ok    = days_in.date_ok;
      tag_in[0].day_number = days_in.day_number;
      tag_in[0].sum_ok     = days_in.sum_ok;
      for (int i = 1; i < TagStages; i++) begin
         tag_in[i] = tag_ff[i - 1];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < TagStages; i++) begin
         if (reset) begin
            tag_ff[i].vld <= 1'b0;
         end else begin
            tag_ff[i].vld <= tag_in[i].vld;
         end
         tag_ff[i].date_ok    <= tag_in[i].date_ok;
         tag_ff[i].day_number <= tag_in[i].day_number;
         tag_ff[i].sum_ok     <= tag_in[i].sum_ok;
      end
   end

   assign era_prod  = 45'(days_in.z) * 45'(cdnc_pkg::Recip146097);
   assign s5_z_in   = days_in.z;
   assign s5_era_in = era_prod[44:cdnc_pkg::Shift146097];

   assign doe_full  = s5_z_ff - 22'(s5_era_ff) * 22'(cdnc_pkg::DaysPerEra);
   assign s6_doe_in = doe_full[17:0];

   always_comb begin
      q1460_prod = 37'(s6_doe_ff) * 37'(cdnc_pkg::Recip1460);
      q1460      = q1460_prod[36:cdnc_pkg::Shift1460];
      q36524     = 3'(s6_doe_ff >= 18'd36524) + 3'(s6_doe_ff >= 18'd73048) +
                   3'(s6_doe_ff >= 18'd109572) + 3'(s6_doe_ff >= 18'd146096);
      q146096    = (s6_doe_ff >= 18'd146096);
      s7_t_in    = s6_doe_ff - 18'(q1460) + 18'(q36524) - 18'(q146096);
   end

   assign yoe_prod  = 37'(s7_t_ff) * 37'(cdnc_pkg::Recip365);
   assign s8_yoe_in = yoe_prod[35:cdnc_pkg::Shift365];

   always_comb begin
      y100      = 2'(s8_yoe_ff >= 9'd100) + 2'(s8_yoe_ff >= 9'd200) +
                  2'(s8_yoe_ff >= 9'd300);
      year_base = 18'(s8_yoe_ff) * 18'd365 + 18'(s8_yoe_ff[8:2]) - 18'(y100);
      doy_full  = s8_doe_ff - year_base;
      s9_doy_in = doy_full[8:0];
   end

   assign mp_num    = 11'(s9_doy_ff) * 11'd5 + 11'd2;
   assign mp_prod   = 23'(mp_num) * 23'(cdnc_pkg::Recip153);
   assign s10_mp_in = mp_prod[22:cdnc_pkg::Shift153];

   always_ff @(posedge clock) begin
      s5_z_ff    <= s5_z_in;
      s5_era_ff  <= s5_era_in;
      s6_doe_ff  <= s6_doe_in;
      s6_era_ff  <= s5_era_ff;
      s7_t_ff    <= s7_t_in;
      s7_doe_ff  <= s6_doe_ff;
      s7_era_ff  <= s6_era_ff;
      s8_yoe_ff  <= s8_yoe_in;
      s8_doe_ff  <= s7_doe_ff;
      s8_era_ff  <= s7_era_ff;
      s9_doy_ff  <= s9_doy_in;
      s9_yoe_ff  <= s8_yoe_ff;
      s9_era_ff  <= s8_era_ff;
      s10_mp_ff  <= s10_mp_in;
      s10_doy_ff <= s9_doy_ff;
      s10_yoe_ff <= s9_yoe_ff;
      s10_era_ff <= s9_era_ff;
   end

   always_comb begin
      day_full  = s10_doy_ff - cdnc_pkg::march_start(s10_mp_ff) + 9'd1;
      month_val = (s10_mp_ff < 4'd10) ? s10_mp_ff + 4'd3 : s10_mp_ff - 4'd9;
      year_val  = 14'(s10_yoe_ff) + 14'(s10_era_ff) * 14'd400 +
                  14'(month_val <= 4'd2);

      out_vld_in        = tag_ff[TagStages - 1].vld;
      out_date_valid_in = tag_ff[TagStages - 1].date_ok;
      out_day_number_in = tag_ff[TagStages - 1].date_ok ?
                          tag_ff[TagStages - 1].day_number : 23'sd0;
      out_sum_valid_in  = tag_ff[TagStages - 1].sum_ok;
      out_sum_year_in   = tag_ff[TagStages - 1].sum_ok ? year_val : 14'd0;
      out_sum_month_in  = tag_ff[TagStages - 1].sum_ok ? month_val : 4'd0;
      out_sum_day_in    = tag_ff[TagStages - 1].sum_ok ? day_full[4:0] : 5'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= out_vld_in;
      end
      out_date_valid_ff <= out_date_valid_in;
      out_day_number_ff <= out_day_number_in;
      out_sum_valid_ff  <= out_sum_valid_in;
      out_sum_year_ff   <= out_sum_year_in;
      out_sum_month_ff  <= out_sum_month_in;
      out_sum_day_ff    <= out_sum_day_in;
   end

   assign res_vld    = out_vld_ff;
   assign date_valid = out_date_valid_ff;
   assign day_number = out_day_number_ff;
   assign sum_valid  = out_sum_valid_ff;
   assign sum_year   = out_sum_year_ff;
   assign sum_month  = out_sum_month_ff;
   assign sum_day    = out_sum_day_ff;

endmodule

// ===== design/civil_date_day_number_convert.sv =====
// Date checker and day arithmetic. Each request carries a Gregorian date and a
// signed day offset; the block returns whether the date is valid, its day number
// from 1970-01-01, and the shifted date. It takes one request every clock: busy is
// always low. The result appears on the rsp_ ports for one cycle, marked by
// rsp_valid, in request order; the receiver cannot hold results off and none is
// needed. Results come from an 11-stage pipeline whose stages each hold one
// constant-reciprocal multiply or one wide add.
module civil_date_day_number_convert (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [13:0]         req_year,
   input  logic [3:0]          req_month,
   input  logic [4:0]          req_day,
   input  logic signed [22:0]  req_day_offset,
   output logic                rsp_valid,
   output logic                rsp_date_valid,
   output logic signed [22:0]  rsp_day_number,
   output logic                rsp_sum_valid,
   output logic [13:0]         rsp_sum_year,
   output logic [3:0]          rsp_sum_month,
   output logic [4:0]          rsp_sum_day
);

   cdnc_pkg::check_type chk;
   cdnc_pkg::days_type  days;
   logic                req_take;

   assign busy     = 1'b0;
   assign req_take = start && !busy;

   cdnc_check u_check (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (req_take),
      .year    (req_year),
      .month   (req_month),
      .day     (req_day),
      .offset  (req_day_offset),
      .chk_out (chk)
   );

   cdnc_to_days u_to_days (
      .clock    (clock),
      .reset    (reset),
      .chk_in   (chk),
      .days_out (days)
   );

   cdnc_from_days u_from_days (
      .clock      (clock),
      .reset      (reset),
      .days_in    (days),
      .res_vld    (rsp_valid),
      .date_valid (rsp_date_valid),
      .day_number (rsp_day_number),
      .sum_valid  (rsp_sum_valid),
      .sum_year   (rsp_sum_year),
      .sum_month  (rsp_sum_month),
      .sum_day    (rsp_sum_day)
   );

endmodule

// ===== design/cdnc_checker.sv =====
module cdnc_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic                rsp_date_valid,
   input logic signed [22:0]  rsp_day_number,
   input logic                rsp_sum_valid,
   input logic [13:0]         rsp_sum_year,
   input logic [3:0]          rsp_sum_month,
   input logic [4:0]          rsp_sum_day
);

   // every result traces back to a request taken a fixed latency earlier
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, cdnc_pkg::PipeDepth))
      else $error("result without matching request");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result right after reset");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_date_valid |-> rsp_day_number == 23'sd0 && !rsp_sum_valid)
      else $error("invalid date with nonzero fields");

   a_sum_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sum_valid |->
         rsp_sum_year == 14'd0 && rsp_sum_month == 4'd0 && rsp_sum_day == 5'd0)
      else $error("out of range sum with nonzero date");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sum_valid |->
         rsp_date_valid && rsp_sum_year != 14'd0 && rsp_sum_year <= 14'd9999 &&
         rsp_sum_month != 4'd0 && rsp_sum_month <= 4'd12 && rsp_sum_day != 5'd0)
      else $error("shifted date out of range");

endmodule

bind civil_date_day_number_convert cdnc_checker u_cdnc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

   localparam int StallLimit = 2000;
   localparam int RandomCount = 1950;
   localparam int CalmFirst = 700;
   localparam int CalmLast = 1000;

   typedef struct packed {
      logic [13:0]        year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [22:0] day_offset;
      logic               drain;
   } date_req_type;

   typedef struct packed {
      logic               date_valid;
      logic signed [22:0] day_number;
      logic               sum_valid;
      logic [13:0]        sum_year;
      logic [3:0]         sum_month;
      logic [4:0]         sum_day;
   } conversion_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [13:0]         req_year = '0;
   logic [3:0]          req_month = '0;
   logic [4:0]          req_day = '0;
   logic signed [22:0]  req_day_offset = '0;
   logic                rsp_valid;
   logic                rsp_date_valid;
   logic signed [22:0]  rsp_day_number;
   logic                rsp_sum_valid;
   logic [13:0]         rsp_sum_year;
   logic [3:0]          rsp_sum_month;
   logic [4:0]          rsp_sum_day;

   date_req_type   pending_dates[$];
   conversion_type expected_conversions[$];
   int             error_count = 0;
   int             launched = 0;
   int             stall_cycles = 0;

   civil_date_day_number_convert dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_year(req_year),
      .req_month(req_month),
      .req_day(req_day),
      .req_day_offset(req_day_offset),
      .rsp_valid(rsp_valid),
      .rsp_date_valid(rsp_date_valid),
      .rsp_day_number(rsp_day_number),
      .rsp_sum_valid(rsp_sum_valid),
      .rsp_sum_year(rsp_sum_year),
      .rsp_sum_month(rsp_sum_month),
      .rsp_sum_day(rsp_sum_day)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int days_in_month(input longint y, input longint m);
      int len;
      case (m)
         1, 3, 5, 7, 8, 10, 12: len = 31;
         4, 6, 9, 11: len = 30;
         2: len = ((y % 400 == 0) || ((y % 100 != 0) && (y % 4 == 0))) ? 29 : 28;
         default: len = 0;
      endcase
      return len;
   endfunction

   function automatic conversion_type convert_date(input date_req_type r);
      conversion_type res;
      longint y, m, d, ya, era, yoe, mi, doy, doe, dn, sum, z, yy, mp, mm, dd;
      res = '0;
      y = r.year;
      m = r.month;
      d = r.day;
      if (y < 1 || y > 9999 || m < 1 || m > 12) return res;
      if (d < 1 || d > days_in_month(y, m)) return res;
      ya = y - ((m <= 2) ? 1 : 0);
      era = ya / 400;
      yoe = ya - era * 400;
      mi = (m > 2) ? m - 3 : m + 9;
      doy = (153 * mi + 2) / 5 + d - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      dn = era * 146097 + doe - 719468;
      res.date_valid = 1'b1;
      res.day_number = dn[22:0];
      sum = dn + longint'($signed(r.day_offset));
      if (sum < longint'(cdnc_pkg::MinDayNumber) || sum > longint'(cdnc_pkg::MaxDayNumber))
         return res;
      z = sum + 719468;
      era = z / 146097;
      doe = z - era * 146097;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      yy = yoe + era * 400;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mp = (5 * doy + 2) / 153;
      dd = doy - (153 * mp + 2) / 5 + 1;
      mm = (mp < 10) ? mp + 3 : mp - 9;
      yy = yy + ((mm <= 2) ? 1 : 0);
      res.sum_valid = 1'b1;
      res.sum_year = yy[13:0];
      res.sum_month = mm[3:0];
      res.sum_day = dd[4:0];
      return res;
   endfunction

   function automatic date_req_type make_req(input int y, input int m, input int d,
                                             input int off, input bit drain);
      date_req_type r;
      r.year = y[13:0];
      r.month = m[3:0];
      r.day = d[4:0];
      r.day_offset = off[22:0];
      r.drain = drain;
      return r;
   endfunction

   task automatic check_field(input string name, input longint exp_v, input longint act_v);
      if (exp_v != act_v) begin
         $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      date_req_type taken;
      date_req_type nxt;
      logic idle;
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            taken.year = req_year;
            taken.month = req_month;
            taken.day = req_day;
            taken.day_offset = req_day_offset;
            taken.drain = 1'b0;
            expected_conversions.push_back(convert_date(taken));
         end
         if (!(start && busy)) begin
            idle = !(launched >= CalmFirst && launched < CalmLast) &&
                   ($urandom_range(0, 99) < 27);
            if (pending_dates.size() != 0 && !idle &&
                !(pending_dates[0].drain && expected_conversions.size() != 0)) begin
               nxt = pending_dates.pop_front();
               start <= 1'b1;
               req_year <= nxt.year;
               req_month <= nxt.month;
               req_day <= nxt.day;
               req_day_offset <= nxt.day_offset;
               launched++;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      conversion_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_conversions.size() == 0) begin
            $display("%0t unexpected response: expected none actual date_valid %0d",
                     $time, rsp_date_valid);
            error_count++;
         end else begin
            exp_r = expected_conversions.pop_front();
            check_field("date_valid", exp_r.date_valid, rsp_date_valid);
            check_field("day_number", exp_r.day_number, rsp_day_number);
            check_field("sum_valid", exp_r.sum_valid, rsp_sum_valid);
            check_field("sum_year", exp_r.sum_year, rsp_sum_year);
            check_field("sum_month", exp_r.sum_month, rsp_sum_month);
            check_field("sum_day", exp_r.sum_day, rsp_sum_day);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
         $display("%0t watchdog expired", $time);
         $display("tb_top failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      date_req_type   r;
      conversion_type base;
      int y, m, d, len, off, kind;

      pending_dates.push_back(make_req(1970, 1, 1, 0, 0));
      pending_dates.push_back(make_req(1, 1, 1, 0, 0));
      pending_dates.push_back(make_req(9999, 12, 31, 0, 0));
      pending_dates.push_back(make_req(1, 1, 1, -1, 0));
      pending_dates.push_back(make_req(9999, 12, 31, 1, 0));
      pending_dates.push_back(make_req(1970, 1, 1, 2932896, 0));
      pending_dates.push_back(make_req(1970, 1, 1, -719162, 0));
      pending_dates.push_back(make_req(2000, 2, 29, 4194303, 0));
      pending_dates.push_back(make_req(2000, 2, 29, -4194304, 0));
      pending_dates.push_back(make_req(1900, 2, 29, 5, 0));
      pending_dates.push_back(make_req(2024, 2, 29, 1, 0));
      pending_dates.push_back(make_req(2023, 2, 29, 1, 0));
      pending_dates.push_back(make_req(2023, 2, 28, 1, 0));
      pending_dates.push_back(make_req(2000, 2, 30, 0, 0));
      pending_dates.push_back(make_req(2021, 4, 31, 0, 0));
      pending_dates.push_back(make_req(0, 6, 15, 0, 0));
      pending_dates.push_back(make_req(10000, 1, 1, 0, 0));
      pending_dates.push_back(make_req(16383, 15, 31, -1, 0));
      pending_dates.push_back(make_req(2021, 0, 10, 0, 0));
      pending_dates.push_back(make_req(2021, 13, 10, 0, 0));
      pending_dates.push_back(make_req(2021, 5, 0, 0, 0));
      pending_dates.push_back(make_req(1600, 3, 1, -1, 0));
      pending_dates.push_back(make_req(2100, 3, 1, -1, 0));
      pending_dates.push_back(make_req(4, 12, 31, 60, 0));
      pending_dates.push_back(make_req(9999, 1, 1, 365, 0));

      for (int i = 0; i < RandomCount; i++) begin
         if ($urandom_range(0, 99) < 12) begin
            r.year = 14'($urandom);
            r.month = 4'($urandom);
            r.day = 5'($urandom);
            r.day_offset = 23'($urandom);
            r.drain = 1'b0;
         end else begin
            case ($urandom_range(0, 3))
               0: y = $urandom_range(1, 12);
               1: y = $urandom_range(9988, 9999);
               2: y = 100 * $urandom_range(1, 99);
               default: y = $urandom_range(1, 9999);
            endcase
            m = $urandom_range(1, 12);
            len = days_in_month(y, m);
            if ($urandom_range(0, 99) < 8) d = len + 1;
            else if ($urandom_range(0, 99) < 15) d = len;
            else d = $urandom_range(1, len);
            r = make_req(y, m, d, 0, 0);
            base = convert_date(r);
            kind = $urandom_range(0, 3);
            case (kind)
               0: off = $urandom_range(0, 4000) - 2000;
               1: off = $urandom;
               2: off = int'(cdnc_pkg::MaxDayNumber) - int'(base.day_number)
                        + $urandom_range(0, 6) - 3;
               default: off = int'(cdnc_pkg::MinDayNumber) - int'(base.day_number)
                              + $urandom_range(0, 6) - 3;
            endcase
            r.day_offset = off[22:0];
         end
         r.drain = (i == 500 || i == 1300);
         pending_dates.push_back(r);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || start) @(posedge clock);
      while (expected_conversions.size() != 0) @(posedge clock);
      repeat (cdnc_pkg::PipeDepth + 8) @(posedge clock);
      if (error_count == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/cdnc_pkg.sv
design/cdnc_check.sv
design/cdnc_to_days.sv
design/cdnc_from_days.sv
design/civil_date_day_number_convert.sv
design/cdnc_checker.sv
bench/tb_top.sv
